### sv/spb_pkg.sv
// shared types and constants of the sorted palette builder
package spb_pkg;

  localparam logic [2:0] OP_CLEAR   = 3'd0;
  localparam logic [2:0] OP_COLLECT = 3'd1;
  localparam logic [2:0] OP_FINISH  = 3'd2;
  localparam logic [2:0] OP_MAP     = 3'd3;
  localparam logic [2:0] OP_READ    = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_NO_ROOM   = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  localparam logic [7:0]  ALPHA_HALF     = 8'h80;
  localparam logic [31:0] QUANT_MASK     = 32'hFFF8F8F8;
  localparam logic [31:0] ALPHA_OPAQUE   = 32'hFF000000;
  localparam logic [31:0] BLUE_ONLY      = 32'h000000FF;
  localparam logic [31:0] MERGED_COLOR   = 32'h00FF00FF;
  localparam logic [31:0] CLEAR_ALPHA    = 32'h00FFFFFF;

  localparam logic [31:0] REG_QUANTIZE   = 32'd0;
  localparam logic [31:0] REG_ZERO_TRANS = 32'd1;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] pixel;
    logic [7:0]  index;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

endpackage

### sv/sorted_palette_builder.sv
// top level of the sorted palette builder
// The block collects the unique colors of one ARGB frame into a table kept in
// ascending order, closes it on finish (optionally reserving index zero for a
// single transparent entry), then maps pixels to indexes and reads entries
// back. Each item gets exactly one result item. The front accepts items into
// a two-entry queue, so the input keeps flowing while a result waits until both
// entries are full; the back handles each item in an evaluate state, where every
// color cell compares against the item, then a commit state, where the cells
// shift for an insert, the index is encoded and the result is registered. The
// commit waits while a result is held unaccepted, and the back takes the next
// item as it commits. The color table has no reset; clear empties count and flags.
module sorted_palette_builder #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // item input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  opcode,
  input  logic [31:0] pixel_color,
  input  logic [7:0]  entry_index,
  // result output
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  color_index,
  output logic [31:0] entry_color,
  output logic [8:0]  color_count,
  output logic [1:0]  status
);

  logic quantize_enable;
  logic zero_transparent_enable;
  logic [31:0] reg_sel;
  spb_pkg::queue_head_t head;
  logic pop;

  // register index is the word address
  assign reg_sel = {31'd0, paddr[2]};
  assign pready  = 1'b1;
  assign prdata  = (reg_sel == spb_pkg::REG_QUANTIZE) ? {31'd0, quantize_enable} :
                   {31'd0, zero_transparent_enable};

  always_ff @(posedge clk) begin
    if (rst) begin
      quantize_enable         <= 1'b0;
      zero_transparent_enable <= 1'b0;
    end else if (psel && penable && pwrite) begin
      if (reg_sel == spb_pkg::REG_QUANTIZE) quantize_enable <= pwdata[0];
      if (reg_sel == spb_pkg::REG_ZERO_TRANS) zero_transparent_enable <= pwdata[0];
    end
  end

  // front: accept and quantize
  spb_front u_front (
    .clk             (clk),
    .rst             (rst),
    .quantize_enable (quantize_enable),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .opcode          (opcode),
    .pixel_color     (pixel_color),
    .entry_index     (entry_index),
    .head            (head),
    .pop             (pop)
  );

  // back: color cells and result register
  spb_back #(
    .DEPTH (PALETTE_DEPTH)
  ) u_back (
    .clk                     (clk),
    .rst                     (rst),
    .zero_transparent_enable (zero_transparent_enable),
    .head                    (head),
    .pop                     (pop),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .color_index             (color_index),
    .entry_color             (entry_color),
    .color_count             (color_count),
    .status                  (status)
  );

endmodule

### sv/spb_front.sv
// front part: item accept, quantize and two-entry queue
module spb_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                quantize_enable,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          opcode,
  input  logic [31:0]         pixel_color,
  input  logic [7:0]          entry_index,
  output spb_pkg::queue_head_t head,
  input  logic                pop
);

  spb_pkg::item_t slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] fill;
  logic       push;
  logic [31:0] qpix;

  always_comb begin
    qpix = pixel_color;
    if (quantize_enable) begin
      if (pixel_color[31:24] >= spb_pkg::ALPHA_HALF) begin
        qpix = pixel_color | spb_pkg::ALPHA_OPAQUE;
      end else begin
        qpix = pixel_color & spb_pkg::BLUE_ONLY;
      end
      qpix = qpix & spb_pkg::QUANT_MASK;
    end
  end

  assign in_ready   = (fill != 2'd2);
  assign push       = in_valid && in_ready;
  assign head.valid = (fill != 2'd0);
  assign head.item  = slots[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= '{op: opcode, pixel: qpix, index: entry_index};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### sv/spb_back.sv
// back part: compare-and-shift color cells, finish, map and read
module spb_back #(
  parameter int DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 zero_transparent_enable,
  input  spb_pkg::queue_head_t head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           color_index,
  output logic [31:0]          entry_color,
  output logic [8:0]           color_count,
  output logic [1:0]           status
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_EVAL   = 3'b010,
    S_COMMIT = 3'b100
  } state_t;

  state_t state, state_next;
  spb_pkg::item_t cur;

  logic [31:0] color_table [DEPTH];
  logic [CW-1:0] entry_count, entry_count_next;
  logic overflow_flag, overflow_flag_next;
  logic palette_finished, palette_finished_next;
  logic [CW-1:0] translucent_count, translucent_count_next;
  logic index_shift_mode, index_shift_mode_next;

  logic [DEPTH-1:0] lt_vec, lt_vec_next;
  logic [DEPTH-1:0] eq_vec, eq_vec_next;
  logic [DEPTH-1:0] tr_vec, tr_vec_next;
  logic [IW-1:0] rd_addr, rd_addr_next;
  logic rd_hit, rd_hit_next;
  logic rd_merged, rd_merged_next;
  logic rd_clr, rd_clr_next;

  logic [CW-1:0] pos;
  logic [CW-1:0] tcnt;
  logic present;
  logic commit_fire;
  logic do_insert;
  logic [8:0] final_cnt;
  logic [8:0] idx9;
  logic [8:0] addr9;

  logic [7:0]  cidx_next;
  logic [31:0] ecol_next;
  logic [8:0]  cnt_out_next;
  logic [1:0]  st_next;

  function automatic logic [CW-1:0] thermo_len(input logic [DEPTH-1:0] v);
    logic [CW-1:0] r;
    r = '0;
    for (int k = 0; k < DEPTH; k++) begin
      if (v[k]) r = CW'(k + 1);
    end
    return r;
  endfunction

  assign commit_fire = (state == S_COMMIT) && (!out_valid || out_ready);
  assign pop = head.valid && ((state == S_IDLE) || commit_fire);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (pop) state_next = S_EVAL;
      S_EVAL:   state_next = S_COMMIT;
      S_COMMIT: begin
        if (commit_fire) state_next = pop ? S_EVAL : S_IDLE;
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // evaluation cycle: every cell compares against the item
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      lt_vec_next[k] = (CW'(k) < entry_count) && (color_table[k] < cur.pixel);
      eq_vec_next[k] = (CW'(k) < entry_count) && (color_table[k] == cur.pixel);
      tr_vec_next[k] = (CW'(k) < entry_count) &&
                       (color_table[k][31:24] < spb_pkg::ALPHA_HALF);
    end
    final_cnt = index_shift_mode ?
                9'(entry_count) + 9'd1 - 9'(translucent_count) : 9'(entry_count);
    idx9 = {1'b0, cur.index};
    addr9 = index_shift_mode ? idx9 + 9'(translucent_count) - 9'd1 : idx9;
    rd_addr_next   = addr9[IW-1:0];
    rd_hit_next    = idx9 < final_cnt;
    rd_merged_next = index_shift_mode && (idx9 == 9'd0);
    rd_clr_next    = !index_shift_mode && (translucent_count == CW'(1)) &&
                     (idx9 == 9'd0);
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= head.item;
    if (state == S_EVAL) begin
      lt_vec    <= lt_vec_next;
      eq_vec    <= eq_vec_next;
      tr_vec    <= tr_vec_next;
      rd_addr   <= rd_addr_next;
      rd_hit    <= rd_hit_next;
      rd_merged <= rd_merged_next;
      rd_clr    <= rd_clr_next;
    end
  end

  assign pos     = thermo_len(lt_vec);
  assign tcnt    = thermo_len(tr_vec);
  assign present = |eq_vec;
  assign do_insert = commit_fire && (cur.op == spb_pkg::OP_COLLECT) &&
                     !palette_finished && !present && (entry_count < CW'(DEPTH));

  // commit cycle: state update and result
  always_comb begin
    entry_count_next       = entry_count;
    overflow_flag_next     = overflow_flag;
    palette_finished_next  = palette_finished;
    translucent_count_next = translucent_count;
    index_shift_mode_next  = index_shift_mode;
    cidx_next = 8'd0;
    ecol_next = 32'd0;
    st_next   = spb_pkg::ST_OK;
    case (cur.op)
      spb_pkg::OP_CLEAR: begin
        entry_count_next       = '0;
        overflow_flag_next     = 1'b0;
        palette_finished_next  = 1'b0;
        translucent_count_next = '0;
        index_shift_mode_next  = 1'b0;
      end
      spb_pkg::OP_COLLECT: begin
        if (!palette_finished) begin
          if (!present) begin
            if (entry_count >= CW'(DEPTH)) overflow_flag_next = 1'b1;
            else entry_count_next = entry_count + CW'(1);
          end
          if (overflow_flag_next) st_next = spb_pkg::ST_OVERFLOW;
        end
      end
      spb_pkg::OP_FINISH: begin
        if (!palette_finished) begin
          if (overflow_flag) begin
            st_next = spb_pkg::ST_OVERFLOW;
          end else begin
            palette_finished_next = 1'b1;
            if (zero_transparent_enable) begin
              if (tcnt == CW'(1)) begin
                translucent_count_next = CW'(1);
              end else if (tcnt == '0 && entry_count >= CW'(DEPTH)) begin
                st_next = spb_pkg::ST_NO_ROOM;
              end else begin
                translucent_count_next = tcnt;
                index_shift_mode_next  = 1'b1;
              end
            end
          end
        end
      end
      spb_pkg::OP_MAP: begin
        st_next = spb_pkg::ST_NOT_FOUND;
        if (palette_finished && present) begin
          st_next = spb_pkg::ST_OK;
          if (index_shift_mode) begin
            cidx_next = (pos < translucent_count) ? 8'd0 :
                        8'(9'(pos) + 9'd1 - 9'(translucent_count));
          end else begin
            cidx_next = 8'(pos);
          end
        end
      end
      spb_pkg::OP_READ: begin
        if (rd_hit) begin
          if (rd_merged) ecol_next = spb_pkg::MERGED_COLOR;
          else if (rd_clr) ecol_next = color_table[0] & spb_pkg::CLEAR_ALPHA;
          else ecol_next = color_table[rd_addr];
        end
      end
      default: ;
    endcase
    cnt_out_next = index_shift_mode_next ?
                   9'(entry_count_next) + 9'd1 - 9'(translucent_count_next) :
                   9'(entry_count_next);
  end

  // shift cells: cells above the insert point take their lower neighbor
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (do_insert && !lt_vec[0]) color_table[0] <= cur.pixel;
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (do_insert) begin
          if (!lt_vec[k-1]) color_table[k] <= color_table[k-1];
          else if (!lt_vec[k]) color_table[k] <= cur.pixel;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit_fire) begin
      color_index <= cidx_next;
      entry_color <= ecol_next;
      color_count <= cnt_out_next;
      status      <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      out_valid         <= 1'b0;
      entry_count       <= '0;
      overflow_flag     <= 1'b0;
      palette_finished  <= 1'b0;
      translucent_count <= '0;
      index_shift_mode  <= 1'b0;
    end else begin
      state <= state_next;
      if (commit_fire) begin
        out_valid         <= 1'b1;
        entry_count       <= entry_count_next;
        overflow_flag     <= overflow_flag_next;
        palette_finished  <= palette_finished_next;
        translucent_count <= translucent_count_next;
        index_shift_mode  <= index_shift_mode_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### sv/spb_checker.sv
// port-level checks of the sorted palette builder
module spb_checker #(
  parameter int PALETTE_DEPTH = 256
) (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  color_index,
  input logic [8:0]  color_count,
  input logic [1:0]  status
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(color_count))
    else $error("result changed while stalled");

  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> color_count <= 9'(PALETTE_DEPTH))
    else $error("count above palette depth");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result after reset");

  a_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == spb_pkg::ST_NOT_FOUND |-> color_index == 8'd0)
    else $error("index given for missing color");

endmodule

bind sorted_palette_builder spb_checker #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .color_index (color_index),
  .color_count (color_count),
  .status      (status)
);
